### rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } out_item_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [1:0] REG_HEAP_START = 2'd0;
  localparam logic [1:0] REG_HEAP_BYTES = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_REBUILD, S_READ, S_CHECK, S_ALLOC, S_FREE_RD, S_RD_P, S_FREE_P,
    S_RD_N, S_FREE_N, S_RESULT
  } state_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE, OP_REBUILD, OP_START, OP_RD_CUR, OP_STEP, OP_ALLOC,
    OP_FREE_RD, OP_RD_PRV, OP_FREE_P, OP_RD_NXT, OP_FREE_N, OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic hit;
  } sts_t;

endpackage
`default_nettype wire

### rtl/first_fit_heap_allocator.sv
`default_nettype none
// First-fit heap allocator: keeps an address-ordered linked table of up to MAX_CHUNKS
// chunks. An allocate or free walks the list one entry at a time through a single table
// read port, and a free then coalesces the freed chunk with free neighbours. Writing
// heap_bytes rebuilds the table; heap_start only moves the base of user addresses.
module first_fit_heap_allocator #(
  parameter int MAX_CHUNKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ffha_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ffha_pkg::out_item_t  out_data,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [2:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  logic [31:0]    heap_start, heap_bytes;
  logic           rebuild_req;
  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start  <= '0;
      heap_bytes  <= '0;
      rebuild_req <= 1'b1;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0 && paddr[1:0] == 2'b00)
        heap_start <= pwdata;
      if (psel && penable && pwrite && paddr[2] == 1'b1 && paddr[1:0] == 2'b00) begin
        heap_bytes  <= pwdata;
        rebuild_req <= 1'b1;
      end else if (cmd.op == ffha_pkg::OP_REBUILD) begin
        rebuild_req <= 1'b0;
      end
    end
  end

  // read mux
  always_comb begin
    unique case ({1'b0, paddr[2]})
      ffha_pkg::REG_HEAP_START: prdata = heap_start;
      ffha_pkg::REG_HEAP_BYTES: prdata = heap_bytes;
      default:                  prdata = '0;
    endcase
  end

  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .rebuild_req (rebuild_req),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (in_data.func),
    .out_busy    (out_valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  ffha_datapath #(
    .MAX_CHUNKS   (MAX_CHUNKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_item    (in_data),
    .heap_start (heap_start),
    .heap_bytes (heap_bytes),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_data)
  );
endmodule
`default_nettype wire

### rtl/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              rebuild_req,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              func,
  input  wire              out_busy,
  input  ffha_pkg::sts_t   sts,
  output ffha_pkg::cmd_t   cmd
);
  ffha_pkg::state_t state, state_next;
  logic             func_r;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ffha_pkg::S_IDLE;
      func_r <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) func_r <= func;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = ffha_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (rebuild_req) begin
          state_next = ffha_pkg::S_REBUILD;
        end else begin
          in_ready = !out_busy;
          if (in_valid && !out_busy) begin
            cmd.op     = ffha_pkg::OP_START;
            state_next = ffha_pkg::S_READ;
          end
        end
      end
      ffha_pkg::S_REBUILD: begin
        cmd.op     = ffha_pkg::OP_REBUILD;
        state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_READ: begin
        if (sts.walk_end) begin
          cmd.op     = ffha_pkg::OP_RESULT;
          state_next = ffha_pkg::S_IDLE;
        end else begin
          cmd.op     = ffha_pkg::OP_RD_CUR;
          state_next = ffha_pkg::S_CHECK;
        end
      end
      ffha_pkg::S_CHECK: begin
        if (sts.hit) begin
          if (func_r == ffha_pkg::FUNC_ALLOC) begin
            cmd.op     = ffha_pkg::OP_ALLOC;
            state_next = ffha_pkg::S_RESULT;
          end else begin
            cmd.op     = ffha_pkg::OP_FREE_RD;
            state_next = ffha_pkg::S_RD_P;
          end
        end else begin
          cmd.op     = ffha_pkg::OP_STEP;
          state_next = ffha_pkg::S_READ;
        end
      end
      ffha_pkg::S_RD_P: begin
        cmd.op     = ffha_pkg::OP_RD_PRV;
        state_next = ffha_pkg::S_FREE_P;
      end
      ffha_pkg::S_FREE_P: begin
        cmd.op     = ffha_pkg::OP_FREE_P;
        state_next = ffha_pkg::S_FREE_RD;
      end
      ffha_pkg::S_FREE_RD: begin
        cmd.op     = ffha_pkg::OP_FREE_RD;
        state_next = ffha_pkg::S_RD_N;
      end
      ffha_pkg::S_RD_N: begin
        cmd.op     = ffha_pkg::OP_RD_NXT;
        state_next = ffha_pkg::S_FREE_N;
      end
      ffha_pkg::S_FREE_N: begin
        cmd.op     = ffha_pkg::OP_FREE_N;
        state_next = ffha_pkg::S_RESULT;
      end
      ffha_pkg::S_RESULT: begin
        cmd.op     = ffha_pkg::OP_RESULT;
        state_next = ffha_pkg::S_IDLE;
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/ffha_datapath.sv
`default_nettype none
module ffha_datapath #(
  parameter int MAX_CHUNKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ffha_pkg::cmd_t       cmd,
  output ffha_pkg::sts_t       sts,
  input  ffha_pkg::in_item_t   in_item,
  input  wire [31:0]           heap_start,
  input  wire [31:0]           heap_bytes,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ffha_pkg::out_item_t  out_item
);
  localparam int IW = $clog2(MAX_CHUNKS + 1);
  localparam int SW = $clog2(MAX_CHUNKS);
  localparam logic [IW-1:0] NIL = IW'(MAX_CHUNKS);
  localparam logic [32:0] HDR = 33'(HEADER_BYTES);

  // chunk table: entries are read one at a time into registers
  logic [31:0]   offs [MAX_CHUNKS];
  logic [31:0]   lens [MAX_CHUNKS];
  logic          used [MAX_CHUNKS];
  logic [IW-1:0] nxt  [MAX_CHUNKS];
  logic [IW-1:0] prv  [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] busy;
  logic [IW-1:0] head;

  logic          func_r;
  logic [31:0]   req, faddr;
  logic [IW-1:0] cur;
  logic [IW:0]   steps;
  logic [31:0]   c_off, c_len;
  logic          c_used;
  logic [IW-1:0] c_nxt, c_prv;
  logic [31:0]   n_len;
  logic          n_used;
  logic [IW-1:0] n_nxt;
  logic [1:0]    res_status;
  logic [31:0]   res_addr;
  logic [SW-1:0] fslot;
  logic          fslot_ok;
  logic [SW-1:0] cs;
  logic [63:0]   ua_full;
  logic [31:0]   ua;
  logic          nxt_ok, prv_ok;
  logic          heap_ok;

  assign cs = cur[SW-1:0];
  assign ua_full = 64'(heap_start) + 64'(c_off) + 64'(HEADER_BYTES);
  assign ua = (ADDRESS_BITS >= 32) ? ua_full[31:0]
            : 32'(ua_full & ((64'd1 << ADDRESS_BITS) - 64'd1));
  assign nxt_ok = c_nxt < NIL;
  assign prv_ok = c_prv < NIL;
  assign heap_ok = heap_bytes >= 32'(HEADER_BYTES);

  // lowest idle slot
  always_comb begin
    fslot    = '0;
    fslot_ok = 1'b0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        fslot    = SW'(i);
        fslot_ok = 1'b1;
      end
    end
  end

  // status to controller
  always_comb begin
    sts.walk_end = !(cur < NIL) || (steps >= (IW + 1)'(MAX_CHUNKS));
    if (func_r == ffha_pkg::FUNC_ALLOC) sts.hit = !c_used && (c_len > req);
    else                                sts.hit = (ua == faddr);
  end

  // result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ffha_pkg::OP_RESULT) out_valid <= 1'b1;
      else if (out_valid && out_ready)   out_valid <= 1'b0;
    end
  end

  // table and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      head <= NIL;
    end else begin
      case (cmd.op)
        ffha_pkg::OP_REBUILD: begin
          busy <= MAX_CHUNKS'(heap_ok);
          head <= heap_ok ? '0 : NIL;
          if (heap_ok) begin
            offs[0] <= '0;
            lens[0] <= heap_bytes - 32'(HEADER_BYTES);
            used[0] <= 1'b0;
            nxt[0]  <= NIL;
            prv[0]  <= NIL;
          end
        end
        ffha_pkg::OP_START: begin
          func_r     <= in_item.func;
          req        <= in_item.request_size;
          faddr      <= in_item.free_address;
          cur        <= head;
          steps      <= '0;
          res_addr   <= '0;
          res_status <= (in_item.func == ffha_pkg::FUNC_ALLOC) ? ffha_pkg::ST_NOFIT
                                                              : ffha_pkg::ST_UNKNOWN;
        end
        ffha_pkg::OP_RD_CUR, ffha_pkg::OP_FREE_RD: begin
          c_off  <= offs[cs];
          c_len  <= lens[cs];
          c_used <= (cmd.op == ffha_pkg::OP_FREE_RD) ? 1'b0 : used[cs];
          c_nxt  <= nxt[cs];
          c_prv  <= prv[cs];
          if (cmd.op == ffha_pkg::OP_FREE_RD) begin
            used[cs]   <= 1'b0;
            res_status <= ffha_pkg::ST_DONE;
          end
        end
        ffha_pkg::OP_STEP: begin
          cur   <= c_nxt;
          steps <= steps + 1'b1;
        end
        ffha_pkg::OP_ALLOC: begin
          used[cs]   <= 1'b1;
          res_addr   <= ua;
          res_status <= ffha_pkg::ST_DONE;
          if (33'(c_len) >= 33'(req) + HDR + 33'd1 && fslot_ok) begin
            offs[fslot] <= 32'(33'(c_off) + HDR + 33'(req));
            lens[fslot] <= 32'(33'(c_len) - 33'(req) - HDR);
            used[fslot] <= 1'b0;
            prv[fslot]  <= cur;
            nxt[fslot]  <= c_nxt;
            busy[fslot] <= 1'b1;
            if (nxt_ok) prv[c_nxt[SW-1:0]] <= IW'(fslot);
            lens[cs] <= req;
            nxt[cs]  <= IW'(fslot);
          end
        end
        // fetch the predecessor entry
        ffha_pkg::OP_RD_PRV: begin
          n_len  <= lens[c_prv[SW-1:0]];
          n_used <= used[c_prv[SW-1:0]];
        end
        ffha_pkg::OP_FREE_P: begin
          // merge into a free predecessor, then continue from it
          if (prv_ok && !n_used) begin
            lens[c_prv[SW-1:0]] <= n_len + c_len + 32'(HEADER_BYTES);
            nxt[c_prv[SW-1:0]]  <= c_nxt;
            if (nxt_ok) prv[c_nxt[SW-1:0]] <= c_prv;
            busy[cs] <= 1'b0;
            cur      <= c_prv;
          end
        end
        // fetch the successor entry
        ffha_pkg::OP_RD_NXT: begin
          n_len  <= lens[c_nxt[SW-1:0]];
          n_used <= used[c_nxt[SW-1:0]];
          n_nxt  <= nxt[c_nxt[SW-1:0]];
        end
        ffha_pkg::OP_FREE_N: begin
          if (nxt_ok && !n_used) begin
            lens[cs] <= c_len + n_len + 32'(HEADER_BYTES);
            nxt[cs]  <= n_nxt;
            if (n_nxt < NIL) prv[n_nxt[SW-1:0]] <= cur;
            busy[c_nxt[SW-1:0]] <= 1'b0;
          end
        end
        ffha_pkg::OP_RESULT: begin
          out_item.granted_address <= res_addr;
          out_item.status          <= res_status;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### tb/sv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;

  localparam int NCH = 64;
  localparam int HDR = 16;
  localparam int NIL = NCH;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffha_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffha_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  first_fit_heap_allocator uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state for the chunk table
  logic [31:0] base_addr, heap_size;
  logic [31:0] c_off [NCH];
  logic [31:0] c_len [NCH];
  logic        c_used [NCH];
  int          c_nxt [NCH];
  int          c_prv [NCH];
  logic        c_busy [NCH];
  int          head;

  ffha_pkg::out_item_t grant_q [$];
  logic [31:0] live_addrs [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 1'b0;

  function automatic logic [31:0] user_of(int s);
    return base_addr + c_off[s] + HDR;
  endfunction

  function automatic void table_rebuild();
    for (int i = 0; i < NCH; i++) begin
      c_off[i] = '0; c_len[i] = '0; c_used[i] = 1'b0;
      c_nxt[i] = 0; c_prv[i] = 0; c_busy[i] = 1'b0;
    end
    head = NIL;
    if (heap_size >= HDR) begin
      c_len[0] = heap_size - HDR;
      c_nxt[0] = NIL; c_prv[0] = NIL; c_busy[0] = 1'b1; head = 0;
    end
  endfunction

  function automatic void merge_into(int a, int b);
    int nx;
    nx = c_nxt[b];
    c_len[a] = c_len[a] + c_len[b] + HDR;
    c_nxt[a] = nx;
    if (nx < NIL) c_prv[nx] = a;
    c_busy[b] = 1'b0;
  endfunction

  function automatic ffha_pkg::out_item_t heap_predict(ffha_pkg::in_item_t it);
    ffha_pkg::out_item_t r;
    int c, hit, steps, s, nx, p, n;
    r = '0;
    c = head; hit = NIL; steps = 0;
    if (it.func == ffha_pkg::FUNC_ALLOC) begin
      while (c < NIL && steps < NCH) begin
        if (!c_used[c] && c_len[c] > it.request_size) begin
          hit = c;
          break;
        end
        c = c_nxt[c]; steps++;
      end
      if (hit == NIL) begin
        r.status = ffha_pkg::ST_NOFIT;
        return r;
      end
      if ({32'd0, c_len[hit]} >= {32'd0, it.request_size} + HDR + 1) begin
        s = NIL;
        for (int i = 0; i < NCH; i++) if (!c_busy[i] && s == NIL) s = i;
        if (s < NIL) begin
          nx = c_nxt[hit];
          c_off[s] = c_off[hit] + HDR + it.request_size;
          c_len[s] = c_len[hit] - it.request_size - HDR;
          c_used[s] = 1'b0; c_prv[s] = hit; c_nxt[s] = nx; c_busy[s] = 1'b1;
          if (nx < NIL) c_prv[nx] = s;
          c_len[hit] = it.request_size;
          c_nxt[hit] = s;
        end
      end
      c_used[hit] = 1'b1;
      r.granted_address = user_of(hit);
      r.status = ffha_pkg::ST_DONE;
      live_addrs.push_back(r.granted_address);
    end else begin
      while (c < NIL && steps < NCH) begin
        if (user_of(c) == it.free_address) begin
          hit = c;
          break;
        end
        c = c_nxt[c]; steps++;
      end
      if (hit == NIL) begin
        r.status = ffha_pkg::ST_UNKNOWN;
        return r;
      end
      c_used[hit] = 1'b0;
      p = c_prv[hit];
      if (p < NIL && !c_used[p]) begin
        merge_into(p, hit);
        hit = p;
      end
      n = c_nxt[hit];
      if (n < NIL && !c_used[n]) merge_into(hit, n);
      r.status = ffha_pkg::ST_DONE;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    ffha_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result got %h/%0d", $time,
                 out_data.granted_address, out_data.status);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (out_data.granted_address !== want.granted_address)
          begin
          $display("%0t: granted_address expected %h got %h", $time,
                   want.granted_address, out_data.granted_address);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // receiver stall and watchdog
  always @(negedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx[0], 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ffha_pkg::REG_HEAP_START) base_addr = val;
    else begin
      heap_size = val;
      table_rebuild();
      live_addrs.delete();
    end
  endtask

  // wait for the block to drain, then let a walk finish
  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (2 * NCH + 20) @(posedge clk);
  endtask

  task automatic send_item(input ffha_pkg::in_item_t it, input logic check_fixed,
                           input ffha_pkg::out_item_t fixed);
    ffha_pkg::out_item_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = heap_predict(it);
    if (check_fixed && p !== fixed) begin
      $display("%0t: table row expected %h/%0d predicted %h/%0d", $time,
               fixed.granted_address, fixed.status, p.granted_address, p.status);
      errors++;
    end
    grant_q.push_back(p);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic ffha_pkg::in_item_t mk_alloc(logic [31:0] sz);
    ffha_pkg::in_item_t it;
    it = '0; it.func = ffha_pkg::FUNC_ALLOC; it.request_size = sz;
    it.free_address = $urandom;
    return it;
  endfunction

  function automatic ffha_pkg::in_item_t mk_free(logic [31:0] a);
    ffha_pkg::in_item_t it;
    it = '0; it.func = ffha_pkg::FUNC_FREE; it.free_address = a;
    it.request_size = $urandom;
    return it;
  endfunction

  typedef struct {
    ffha_pkg::in_item_t it;
    logic fixed;
    ffha_pkg::out_item_t want;
  } stim_row_t;

  stim_row_t rows [$];
  ffha_pkg::in_item_t it;
  int k, sel;
  logic [31:0] a;

  initial begin
    for (int i = 0; i < 10; i++) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    base_addr = '0; heap_size = '0; table_rebuild();

    // directed: empty table, then a heap of 1 KiB
    rows.push_back('{mk_alloc(32'd0), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT}});
    rows.push_back('{mk_free(32'd16), 1'b1, '{32'd0, ffha_pkg::ST_UNKNOWN}});
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].want);
    drain();
    rows.delete();
    reg_write(ffha_pkg::REG_HEAP_START, 32'h1000_0000);
    reg_write(ffha_pkg::REG_HEAP_BYTES, 32'd1024);
    rows.push_back('{mk_alloc(32'd1008), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT}});
    rows.push_back('{mk_alloc(32'hFFFF_FFFF), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT}});
    rows.push_back('{mk_alloc(32'd0), 1'b1, '{32'h1000_0010, ffha_pkg::ST_DONE}});
    rows.push_back('{mk_alloc(32'd100), 1'b0, '0});
    rows.push_back('{mk_alloc(32'd200), 1'b0, '0});
    rows.push_back('{mk_free(32'h1000_0010), 1'b1, '{32'd0, ffha_pkg::ST_DONE}});
    rows.push_back('{mk_free(32'h1000_0010), 1'b1, '{32'd0, ffha_pkg::ST_DONE}});
    rows.push_back('{mk_free(32'hFFFF_FFFF), 1'b1, '{32'd0, ffha_pkg::ST_UNKNOWN}});
    rows.push_back('{mk_alloc(32'd690), 1'b0, '0});
    rows.push_back('{mk_alloc(32'd1), 1'b0, '0});
    rows.push_back('{mk_free(32'h1000_0021), 1'b0, '0});
    rows.push_back('{mk_alloc(32'd5), 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].want);
    drain();

    // high base so user addresses wrap, and the largest heap
    reg_write(ffha_pkg::REG_HEAP_START, 32'hFFFF_FFF8);
    reg_write(ffha_pkg::REG_HEAP_BYTES, 32'hFFFF_FFFF);
    send_item(mk_alloc(32'hFFFF_FFEE), 1'b1, '{32'h0000_0008, ffha_pkg::ST_DONE});
    send_item(mk_alloc(32'd0), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT});
    send_item(mk_free(32'h0000_0008), 1'b1, '{32'd0, ffha_pkg::ST_DONE});
    drain();
    reg_write(ffha_pkg::REG_HEAP_BYTES, 32'd15);
    send_item(mk_alloc(32'd0), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT});
    drain();
    reg_write(ffha_pkg::REG_HEAP_BYTES, 32'd16);
    send_item(mk_alloc(32'd0), 1'b1, '{32'd0, ffha_pkg::ST_NOFIT});
    drain();

    // random phases with varying idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 54; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 54; end
        3: begin send_idle = 15; recv_stall = 15; end
        4: begin send_idle = 0; recv_stall = 0; end
        default: begin send_idle = $urandom_range(30); recv_stall = $urandom_range(30); end
      endcase
      reg_write(ffha_pkg::REG_HEAP_START, $urandom);
      reg_write(ffha_pkg::REG_HEAP_BYTES,
                (ph == 5) ? $urandom : 32'd200 + $urandom_range(4000));
      // long receiver hold-off while items keep coming
      if (ph == 4) fork
        begin
          hold_off = 1'b1;
          repeat (3000) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < 155; n++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          k = $urandom_range(99);
          if (k < 80) it = mk_alloc($urandom_range(120));
          else if (k < 95) it = mk_alloc($urandom_range(2000));
          else it = mk_alloc($urandom);
        end else if (sel < 88 && live_addrs.size() != 0) begin
          k = $urandom_range(live_addrs.size() - 1);
          a = live_addrs[k];
          live_addrs.delete(k);
          it = mk_free(a);
        end else begin
          a = $urandom;
          if (sel > 95 && live_addrs.size() != 0) a = live_addrs[0] + 1;
          it = mk_free(a);
        end
        send_item(it, 1'b0, '0);
      end
      while (hold_off) @(posedge clk);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_datapath.sv
rtl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
